@@ rtl/eeu_pkg.sv @@
// ============================================================================
// eeu_pkg
// Shared types, register codes and constants of the data EEPROM controller.
// ============================================================================
package eeu_pkg;

    // Store geometry. The depth is a power of two; the address register
    // indexes the store through its low bits.
    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [15:0] WRITE_TICKS_RESET = 16'd1000;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Register selectors.
    localparam logic [2:0] SEL_DATA    = 3'd0;
    localparam logic [2:0] SEL_ADDRESS = 3'd1;
    localparam logic [2:0] SEL_CONTROL = 3'd2;
    localparam logic [2:0] SEL_UNLOCK  = 3'd3;
    localparam logic [2:0] SEL_FLAG    = 3'd4;

    // Unlock sequence bytes and sequencer steps.
    localparam logic [7:0] UNLOCK_FIRST  = 8'h55;
    localparam logic [7:0] UNLOCK_SECOND = 8'hAA;
    localparam logic [1:0] STEP_IDLE     = 2'd0;
    localparam logic [1:0] STEP_FIRST    = 2'd1;
    localparam logic [1:0] STEP_ARMED    = 2'd2;

    // Control and flag register bit positions.
    localparam int CTL_RD_BIT    = 0;
    localparam int CTL_WR_BIT    = 1;
    localparam int CTL_WREN_BIT  = 2;
    localparam int FLAG_DONE_BIT = 4;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Command kinds produced by the decoder.
    typedef logic [3:0] cmd_kind_t;
    localparam cmd_kind_t CMD_NOP       = 4'd0;
    localparam cmd_kind_t CMD_READ      = 4'd1;
    localparam cmd_kind_t CMD_WR_DATA   = 4'd2;
    localparam cmd_kind_t CMD_WR_ADDR   = 4'd3;
    localparam cmd_kind_t CMD_WR_CTL    = 4'd4;
    localparam cmd_kind_t CMD_WR_UNLOCK = 4'd5;
    localparam cmd_kind_t CMD_WR_FLAG   = 4'd6;
    localparam cmd_kind_t CMD_WR_OTHER  = 4'd7;
    localparam cmd_kind_t CMD_TICK      = 4'd8;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [2:0]  reg_sel;
        logic [7:0]  reg_data;
    } cmd_t;

endpackage

@@ rtl/eeu_if.sv @@
// ============================================================================
// eeu_if
// Valid/ready channels of the data EEPROM controller.
// ============================================================================
interface eeu_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [2:0] reg_sel;
    logic [7:0] reg_data;

    modport source (output valid, output req_type, output reg_sel, output reg_data,
                    input ready);
    modport sink   (input valid, input req_type, input reg_sel, input reg_data,
                    output ready);
endinterface

interface eeu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       write_busy;
    logic       done_flag;

    modport source (output valid, output read_data, output write_busy,
                    output done_flag, input ready);
    modport sink   (input valid, input read_data, input write_busy,
                    input done_flag, output ready);
endinterface

interface eeu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] write_ticks;

    modport source (output valid, output write_ticks, input ready);
    modport sink   (input valid, input write_ticks, output ready);
endinterface

@@ rtl/eeu_front.sv @@
// ============================================================================
// eeu_front
// Accepts bus items and classifies them into commands for the queue.
// ============================================================================
module eeu_front (
    eeu_req_if.sink         req,
    output eeu_pkg::cmd_t   push_cmd,
    output logic            push_valid,
    input  logic            push_ready
);
    import eeu_pkg::*;

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

    always_comb
    begin
        push_cmd.reg_sel  = req.reg_sel;
        push_cmd.reg_data = req.reg_data;
        unique case (req.req_type)
            REQ_READ:
                push_cmd.kind = CMD_READ;
            REQ_WRITE:
            begin
                unique case (req.reg_sel)
                    SEL_DATA:    push_cmd.kind = CMD_WR_DATA;
                    SEL_ADDRESS: push_cmd.kind = CMD_WR_ADDR;
                    SEL_CONTROL: push_cmd.kind = CMD_WR_CTL;
                    SEL_UNLOCK:  push_cmd.kind = CMD_WR_UNLOCK;
                    SEL_FLAG:    push_cmd.kind = CMD_WR_FLAG;
                    default:     push_cmd.kind = CMD_WR_OTHER;
                endcase
            end
            REQ_TICK:
                push_cmd.kind = CMD_TICK;
            default:
                push_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

@@ rtl/eeu_queue.sv @@
// ============================================================================
// eeu_queue
// Two-entry command queue between the decoder and the execution unit.
// ============================================================================
module eeu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  eeu_pkg::cmd_t   push_cmd,
    input  logic            push_valid,
    output logic            push_ready,
    output eeu_pkg::cmd_t   head_cmd,
    output logic            head_valid,
    input  logic            head_take
);
    import eeu_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = head_take && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/eeu_back.sv @@
// ============================================================================
// eeu_back
// Executes commands against the register file and the byte store, and holds
// the result register.
// ============================================================================
module eeu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  eeu_pkg::cmd_t   head_cmd,
    input  logic            head_valid,
    output logic            head_take,
    eeu_cfg_if.sink         cfg,
    eeu_rsp_if.source       rsp
);
    import eeu_pkg::*;

    logic [7:0]             store_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] written_reg;
    logic [7:0]             mem_q_reg;
    logic                   mem_q_ok_reg;

    logic [15:0] ticks_reg;
    logic [7:0]  data_reg,      data_next;
    logic        data_mem_reg,  data_mem_next;
    logic [7:0]  addr_reg,      addr_next;
    logic        wren_reg,      wren_next;
    logic        active_reg,    active_next;
    logic [1:0]  step_reg,      step_next;
    logic [15:0] cnt_reg,       cnt_next;
    logic [7:0]  paddr_reg,     paddr_next;
    logic [7:0]  pdata_reg,     pdata_next;
    logic        pmem_reg,      pmem_next;
    logic        done_reg,      done_next;

    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_busy_reg;
    logic        out_done_reg;

    logic        fire;
    logic        rd_issue;
    logic        mem_we;
    logic [7:0]  rd_val;
    logic [7:0]  mem_eff;
    logic [7:0]  data_eff;
    logic [7:0]  pdata_eff;
    logic [7:0]  v;

    // A byte loaded by RD lives in the store's read register until something
    // replaces it; the data and pending-data registers point at it by a flag.
    assign mem_eff   = mem_q_ok_reg ? mem_q_reg : ERASED_BYTE;
    assign data_eff  = data_mem_reg ? mem_eff : data_reg;
    assign pdata_eff = pmem_reg ? mem_eff : pdata_reg;

    assign fire      = head_valid && (!out_valid_reg || rsp.ready);
    assign head_take = fire;
    assign v         = head_cmd.reg_data;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        data_next     = data_reg;
        data_mem_next = data_mem_reg;
        addr_next     = addr_reg;
        wren_next     = wren_reg;
        active_next   = active_reg;
        step_next     = step_reg;
        cnt_next      = cnt_reg;
        paddr_next    = paddr_reg;
        pdata_next    = pdata_reg;
        pmem_next     = pmem_reg;
        done_next     = done_reg;
        rd_val        = 8'd0;
        rd_issue      = 1'b0;
        mem_we        = 1'b0;
        if (fire)
        begin
            unique case (head_cmd.kind)
                CMD_READ:
                begin
                    case (head_cmd.reg_sel)
                        SEL_DATA:    rd_val = data_eff;
                        SEL_ADDRESS: rd_val = addr_reg;
                        SEL_CONTROL: rd_val = {5'd0, wren_reg, active_reg, 1'b0};
                        SEL_FLAG:    rd_val = {3'd0, done_reg, 4'd0};
                        default:     rd_val = 8'd0;
                    endcase
                end
                CMD_WR_UNLOCK:
                begin
                    if (v == UNLOCK_FIRST)
                    begin
                        step_next = STEP_FIRST;
                    end
                    else if (v == UNLOCK_SECOND && step_reg == STEP_FIRST)
                    begin
                        step_next = STEP_ARMED;
                    end
                    else
                    begin
                        step_next = STEP_IDLE;
                    end
                end
                CMD_WR_CTL:
                begin
                    step_next = STEP_IDLE;
                    wren_next = v[CTL_WREN_BIT];
                    if (v[CTL_RD_BIT])
                    begin
                        rd_issue      = 1'b1;
                        data_mem_next = 1'b1;
                        // The read register is about to change: settle a
                        // pending byte that still points at it.
                        if (pmem_reg)
                        begin
                            pdata_next = mem_eff;
                            pmem_next  = 1'b0;
                        end
                    end
                    if (v[CTL_WR_BIT] && v[CTL_WREN_BIT] && step_reg == STEP_ARMED
                        && !active_reg)
                    begin
                        paddr_next  = addr_reg;
                        pdata_next  = data_eff;
                        pmem_next   = v[CTL_RD_BIT];
                        cnt_next    = (ticks_reg == 16'd0) ? 16'd1 : ticks_reg;
                        active_next = 1'b1;
                    end
                end
                CMD_WR_DATA:
                begin
                    step_next     = STEP_IDLE;
                    data_next     = v;
                    data_mem_next = 1'b0;
                end
                CMD_WR_ADDR:
                begin
                    step_next = STEP_IDLE;
                    addr_next = v;
                end
                CMD_WR_FLAG:
                begin
                    step_next = STEP_IDLE;
                    if (!v[FLAG_DONE_BIT])
                    begin
                        done_next = 1'b0;
                    end
                end
                CMD_WR_OTHER:
                begin
                    step_next = STEP_IDLE;
                end
                CMD_TICK:
                begin
                    if (active_reg)
                    begin
                        if (cnt_reg <= 16'd1)
                        begin
                            mem_we      = 1'b1;
                            active_next = 1'b0;
                            done_next   = 1'b1;
                            cnt_next    = 16'd0;
                        end
                        else
                        begin
                            cnt_next = cnt_reg - 16'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg     <= WRITE_TICKS_RESET;
            data_reg      <= 8'd0;
            data_mem_reg  <= 1'b0;
            addr_reg      <= 8'd0;
            wren_reg      <= 1'b0;
            active_reg    <= 1'b0;
            step_reg      <= STEP_IDLE;
            cnt_reg       <= 16'd0;
            paddr_reg     <= 8'd0;
            pdata_reg     <= 8'd0;
            pmem_reg      <= 1'b0;
            done_reg      <= 1'b0;
            written_reg   <= '0;
            mem_q_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                ticks_reg <= cfg.write_ticks;
            end
            data_reg     <= data_next;
            data_mem_reg <= data_mem_next;
            addr_reg     <= addr_next;
            wren_reg     <= wren_next;
            active_reg   <= active_next;
            step_reg     <= step_next;
            cnt_reg      <= cnt_next;
            paddr_reg    <= paddr_next;
            pdata_reg    <= pdata_next;
            pmem_reg     <= pmem_next;
            done_reg     <= done_next;
            if (mem_we)
            begin
                written_reg[paddr_reg[ADDR_W-1:0]] <= 1'b1;
            end
            if (rd_issue)
            begin
                mem_q_ok_reg <= written_reg[addr_reg[ADDR_W-1:0]];
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Byte store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[paddr_reg[ADDR_W-1:0]] <= pdata_eff;
        end
        if (rd_issue)
        begin
            mem_q_reg <= store_mem[addr_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= rd_val;
            out_busy_reg <= active_next;
            out_done_reg <= done_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.write_busy = out_busy_reg;
    assign rsp.done_flag  = out_done_reg;

    // A running cycle always has ticks left, and an idle one has none.
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cnt_reg != 16'd0))
        else $error("programming cycle running with zero tick count");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (cnt_reg == 16'd0))
        else $error("tick count nonzero while no cycle runs");

    // The store is written only at the end of a running cycle, which sets the flag.
    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (!active_reg && done_reg))
        else $error("store write without cycle completion");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != 2'd3)
        else $error("unlock sequencer in unused step");

    // A result is not dropped while the consumer stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("result register changed while stalled");

endmodule

@@ rtl/data_eeprom_unlock_controller_top.sv @@
// ============================================================================
// data_eeprom_unlock_controller_top
// Data EEPROM controller with unlock sequence, seen through byte registers.
// ============================================================================
// Each bus item (register read, register write or one tick) yields exactly
// one result item. The block sustains one item per clock cycle while results
// are taken as they appear. A result is registered in the result register
// once its command has left the command queue. The pace is set by the
// execution unit, which retires one command per cycle unless a result waits
// untaken, through a single registered read port and a single write port of
// the byte store. A two-entry command queue sits between the decoder and the
// execution unit, and lets a new item be accepted while a result still waits.
// The store reads as erased (0xFF) after reset through per-byte written flags,
// so there is no clearing pass and the block is ready right out of reset. The
// write_ticks register may be written only while no item is in flight.
module data_eeprom_unlock_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    eeu_req_if.sink     req,
    eeu_cfg_if.sink     cfg,
    eeu_rsp_if.source   rsp
);
    import eeu_pkg::*;

    cmd_t push_cmd;
    logic push_valid;
    logic push_ready;
    cmd_t head_cmd;
    logic head_valid;
    logic head_take;

    eeu_front u_front (
        .req        (req),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    eeu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .head_take  (head_take)
    );

    eeu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .head_take  (head_take),
        .cfg        (cfg),
        .rsp        (rsp)
    );

endmodule
